/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srbd_pkg.sv */
package srbd_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // Read address sources for the record store.
  localparam logic [1:0] RD_FILL  = 2'd0;
  localparam logic [1:0] RD_SHIFT = 2'd1;
  localparam logic [1:0] RD_EMIT  = 2'd2;

  typedef struct packed {
    logic [31:0] record_id;
    logic [31:0] distance_bits;
    logic [31:0] payload;
    logic        last_record;
  } in_rec_t;

  typedef struct packed {
    logic [31:0] out_id;
    logic [31:0] out_distance;
    logic [31:0] out_payload;
    logic        out_last;
    logic        overflow;
  } out_rec_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] key;
    logic [31:0] data;
  } store_rec_t;

  typedef struct packed {
    logic       capture;
    logic       shift;
    logic       place;
    logic       emit_load;
    logic       clr_set;
    logic [1:0] rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic full;
    logic pos_one;
    logic key_gt;
    logic k_last;
    logic hold_last;
    logic in_last;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/srbd_if.sv */
interface srbd_in_if import srbd_pkg::*;;
  logic    valid;
  logic    ready;
  in_rec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srbd_out_if import srbd_pkg::*;;
  logic     valid;
  logic     ready;
  out_rec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/srbd_datapath.sv */
`include "assert_macros.svh"

module srbd_datapath import srbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  in_rec_t    in_data,
  output logic       out_valid,
  output out_rec_t   out_data,
  input  logic       out_ready
);

  store_rec_t mem [MAX_RECORDS];

  store_rec_t hold_r;
  logic       hold_last_r;
  store_rec_t rd_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] k_r;
  logic       ovf_r;
  out_rec_t   out_r;
  logic       out_valid_r;

  logic [CNT_W-1:0]  fill_m1;
  logic [CNT_W-1:0]  pos_m2;
  logic [CNT_W-1:0]  k_p1;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  store_rec_t        wr_data;
  logic              wr_en;
  logic              full;

  assign fill_m1 = fill_r - CNT_W'(1);
  assign pos_m2  = pos_r - CNT_W'(2);
  assign k_p1    = k_r + CNT_W'(1);
  assign full    = (fill_r == CNT_W'(MAX_RECORDS));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_FILL:  rd_addr = fill_m1[ADDR_W-1:0];
      RD_SHIFT: rd_addr = pos_m2[ADDR_W-1:0];
      RD_EMIT:  rd_addr = k_r[ADDR_W-1:0];
      default:  rd_addr = k_r[ADDR_W-1:0];
    endcase
  end

  assign wr_en   = cmd.shift | cmd.place;
  assign wr_addr = pos_r[ADDR_W-1:0];
  assign wr_data = cmd.shift ? rd_r : hold_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_r.id   <= in_data.record_id;
      hold_r.key  <= in_data.distance_bits;
      hold_r.data <= in_data.payload;
      hold_last_r <= in_data.last_record;
    end
    if (cmd.emit_load) begin
      out_r.out_id       <= rd_r.id;
      out_r.out_distance <= rd_r.key;
      out_r.out_payload  <= rd_r.data;
      out_r.out_last     <= (k_p1 == fill_r);
      out_r.overflow     <= ovf_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        pos_r <= fill_r;
        if (full) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.shift) begin
        pos_r <= pos_r - CNT_W'(1);
      end
      if (cmd.place) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (cmd.emit_load) begin
        k_r         <= k_p1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr_set) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
        k_r    <= '0;
      end
    end
  end

  assign status.fill_zero = (fill_r == '0);
  assign status.full      = full;
  assign status.pos_one   = (pos_r == CNT_W'(1));
  assign status.key_gt    = (rd_r.key > hold_r.key);
  assign status.k_last    = (k_p1 == fill_r);
  assign status.hold_last = hold_last_r;
  assign status.in_last   = in_data.last_record;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_ALWAYS(a_fill_bound, fill_r <= CNT_W'(MAX_RECORDS), "fill count beyond capacity")
  `ASSERT_IMPLIES(a_shift_pos, cmd.shift, pos_r != '0, "shift below the bottom of the store")
  `ASSERT_NEXT(a_place_fill, cmd.place && !cmd.clr_set, fill_r == $past(fill_r) + CNT_W'(1),
    "placement did not grow the fill count")
  `ASSERT_IMPLIES(a_emit_range, cmd.emit_load, k_r < fill_r, "emit index past the stored set")

endmodule

/* rtl/srbd_ctrl.sv */
module srbd_ctrl import srbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_COMP    = 3'd1;
  localparam logic [2:0] S_PLACE   = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_LD = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_FILL;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (status.full) begin
            state_nxt = status.in_last ? S_EMIT_RD : S_IDLE;
          end else if (status.fill_zero) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_COMP;
          end
        end
      end
      S_COMP: begin
        cmd.rd_sel = RD_SHIFT;
        if (status.key_gt) begin
          cmd.shift = 1'b1;
          state_nxt = status.pos_one ? S_PLACE : S_COMP;
        end else begin
          cmd.place = 1'b1;
          state_nxt = status.hold_last ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = status.hold_last ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        cmd.rd_sel = RD_EMIT;
        state_nxt  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.rd_sel = RD_EMIT;
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.k_last) begin
            cmd.clr_set = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sort_records_by_distance.sv */
// Load: a record is accepted, walked past each stored record with a larger key and then placed;
// no new record is accepted until the previous one has been placed or dropped.
// Emit: after the marked record is placed or dropped, the sorted set leaves one result at a time
// through the single store read port: each entry is read in EMIT_RD and loaded in EMIT_LD, which
// waits while the output register still holds a result, such as the previous set's last result.
// Synchronous active-low reset empties the set and clears overflow; store contents stay undefined.

// The block keeps the current set in a 64-entry record store, always held in
// ascending key order. An arriving record is inserted at the top and walked
// down: each cycle the entry just below is compared against the new key and,
// when it is strictly larger, moved up by one. Equal keys therefore stay in
// arrival order. A record that arrives with the store full is dropped and the
// overflow flag is raised for the whole set.
//
// When the marked record has been handled, the controller reads the store from
// the bottom and loads each entry into the output register. The output
// register decouples the result channel, so a finished result may wait there
// while the block already accepts the first request of the next set.
module sort_records_by_distance import srbd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  srbd_in_if.sink  in_rec,
  srbd_out_if.source out_rec
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_rec_t   out_data;

  // The controller sequences insertion and emission.
  srbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rec.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the counters and the output register.
  srbd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_rec.data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_rec.ready)
  );

  assign in_rec.ready  = in_ready;
  assign out_rec.valid = out_valid;
  assign out_rec.data  = out_data;

endmodule

/* tb/sv/sorted_record_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the record sorter. It keeps its own ranked copy of
// the current set, turns each finished set into the ordered results it owes,
// and checks every result that leaves the block against the oldest one owed.
module sorted_record_checker import srbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  srbd_in_if   in_mon,
  srbd_out_if  out_mon,
  output int   mismatches,
  output int   results_owed,
  output int   results_seen
);

  store_rec_t ranked[MAX_RECORDS];
  int         ranked_count;
  logic       dropped_any;
  out_rec_t   results_due[$];
  int         err_tally;
  int         seen_tally;

  // Stable insertion: larger keys move up, equal keys stay ahead of the new one.
  task automatic insert_ranked(input in_rec_t rec);
    int pos;
    pos = ranked_count;
    while (pos > 0 && ranked[pos - 1].key > rec.distance_bits) begin
      ranked[pos] = ranked[pos - 1];
      pos--;
    end
    ranked[pos].id   = rec.record_id;
    ranked[pos].key  = rec.distance_bits;
    ranked[pos].data = rec.payload;
    ranked_count++;
  endtask

  task automatic take_record(input in_rec_t rec);
    out_rec_t owed;
    if (ranked_count < MAX_RECORDS) begin
      insert_ranked(rec);
    end else begin
      dropped_any = 1'b1;
    end
    if (rec.last_record) begin
      for (int k = 0; k < ranked_count; k++) begin
        owed.out_id       = ranked[k].id;
        owed.out_distance = ranked[k].key;
        owed.out_payload  = ranked[k].data;
        owed.out_last     = (k == ranked_count - 1);
        owed.overflow     = dropped_any;
        results_due.push_back(owed);
      end
      ranked_count = 0;
      dropped_any  = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_tally++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_rec_t want;
    out_rec_t got;
    if (!rst_n) begin
      ranked_count = 0;
      dropped_any  = 1'b0;
      results_due.delete();
      err_tally    = 0;
      seen_tally   = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        take_record(in_mon.data);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          err_tally++;
        end else begin
          want = results_due.pop_front();
          check_field("out_id", want.out_id, got.out_id);
          check_field("out_distance", want.out_distance, got.out_distance);
          check_field("out_payload", want.out_payload, got.out_payload);
          check_field("out_last", 32'(want.out_last), 32'(got.out_last));
          check_field("overflow", 32'(want.overflow), 32'(got.overflow));
          seen_tally++;
        end
      end
    end
    mismatches   <= err_tally;
    results_owed <= results_due.size();
    results_seen <= seen_tally;
  end

endmodule

/* tb/sv/tb_sort_records_by_distance.sv */
`timescale 1ns / 1ps

// Top of the record sorter bench. This module only makes stimulus and gives
// the verdict; all prediction and comparison lives in the checker instance.
module tb_sort_records_by_distance;
  import srbd_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  srbd_in_if  in_ch();
  srbd_out_if out_ch();

  int mismatches;
  int results_owed;
  int results_seen;

  // Stimulus bookkeeping for the closing summary.
  int records_sent;
  int sets_sent;
  int full_sets;

  // Calm counters give stretches where a side never idles.
  int send_calm;
  int take_calm;

  always #5 clk = ~clk;

  sort_records_by_distance DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rec  (in_ch),
    .out_rec (out_ch)
  );

  sorted_record_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .results_owed (results_owed),
    .results_seen (results_seen)
  );

  // Draws the number of idle cycles before the next request on one side.
  // Now and then a calm stretch starts in which no idling happens at all.
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 30);
    end
    return $urandom_range(0, 5);
  endfunction

  // Sends one record and returns once the block has taken it. Valid stays
  // high afterwards, so back-to-back requests never drop it within a step.
  task automatic send_record(input logic [31:0] id, input logic [31:0] key_bits,
                             input logic [31:0] data, input logic last);
    int gap;
    gap = draw_pause(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data.record_id     <= id;
    in_ch.data.distance_bits <= key_bits;
    in_ch.data.payload       <= data;
    in_ch.data.last_record   <= last;
    in_ch.valid              <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    records_sent++;
    if (last) begin
      sets_sent++;
    end
  endtask

  // Holds the sender off until every result owed so far has left the block.
  // The first edge lets the checker count a set that ended on the last edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Key shapes: a tiny pool to force ties, fully random bits, positive floats,
  // and small keys, some with the sign bit set, which must sort above every positive one.
  function automatic logic [31:0] pick_key(input int style);
    case (style)
      0: return 32'($urandom_range(0, 3));
      1: return $urandom();
      2: return $urandom() & 32'h7FFF_FFFF;
      default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0)
                      | 32'($urandom_range(0, 7));
    endcase
  endfunction

  // One complete set with random ids, payloads and keys of the given shape.
  task automatic send_set(input int count, input int style);
    for (int k = 0; k < count; k++) begin
      send_record($urandom(), pick_key(style), $urandom(), k == count - 1);
    end
    if (count > MAX_RECORDS) begin
      full_sets++;
    end
  endtask

  // Result side: before every result it idles a random number of cycles,
  // then keeps ready high until a result is taken.
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_pause(take_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    int size;
    int style;
    int first_big;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    records_sent = 0;
    sets_sent    = 0;
    full_sets    = 0;
    send_calm    = 0;
    take_calm    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Sets of one record carry the field extremes.
    send_record(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_record(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

    // Equal keys must come out in arrival order, and a key with the sign
    // bit set must land after all the positive ones.
    send_record(32'd1, 32'd5, 32'hA000_0001, 1'b0);
    send_record(32'd2, 32'd5, 32'hA000_0002, 1'b0);
    send_record(32'd3, 32'h8000_0000, 32'hA000_0003, 1'b0);
    send_record(32'd4, 32'd3, 32'hA000_0004, 1'b0);
    send_record(32'd5, 32'd5, 32'hA000_0005, 1'b0);
    send_record(32'd6, 32'h0000_0000, 32'hA000_0006, 1'b1);

    // Strictly descending keys make every insertion walk the whole set.
    send_record(32'd7, 32'h7F7F_FFFF, 32'h5555_5555, 1'b0);
    send_record(32'd8, 32'h3F80_0000, 32'hAAAA_AAAA, 1'b0);
    send_record(32'd9, 32'h0000_0001, 32'h0F0F_0F0F, 1'b0);
    send_record(32'd10, 32'h0000_0000, 32'hF0F0_F0F0, 1'b1);

    // Already ascending keys need no shifting at all.
    send_record(32'd11, 32'h3F00_0000, 32'h1234_5678, 1'b0);
    send_record(32'd12, 32'h3F80_0000, 32'h9ABC_DEF0, 1'b0);
    send_record(32'd13, 32'h4000_0000, 32'h0000_0001, 1'b1);

    // Let the block drain completely before the random part.
    wait_drained();

    // Random part. It opens with a set that exactly fills the store and one
    // whose marked record arrives with the store full and is dropped.
    first_big = 2;
    while (records_sent < 370) begin
      style = $urandom_range(0, 3);
      if (first_big == 2) begin
        size = MAX_RECORDS;
      end else if (first_big == 1) begin
        size = MAX_RECORDS + 1;
      end else if ($urandom_range(0, 24) == 0) begin
        size = $urandom_range(MAX_RECORDS - 4, MAX_RECORDS + 6);
      end else begin
        size = $urandom_range(1, 12);
      end
      if (first_big > 0) begin
        first_big--;
      end
      send_set(size, style);
      // Occasionally the sender waits for the whole backlog to clear.
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end

    // Wait for every owed result, then a few cycles in case of strays.
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d records in %0d sets, %0d of them past capacity.",
             records_sent, sets_sent, full_sets);
    $display("Checked %0d sorted results against the prediction.", results_seen);
    if (mismatches == 0) begin
      $display("sort_records_by_distance test passed");
    end else begin
      $display("sort_records_by_distance test failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still owed.", results_owed);
    $display("sort_records_by_distance test failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/srbd_pkg.sv
rtl/srbd_if.sv
rtl/srbd_datapath.sv
rtl/srbd_ctrl.sv
rtl/sort_records_by_distance.sv
tb/sv/sorted_record_checker.sv
tb/sv/tb_sort_records_by_distance.sv
